>>> sv/deq_pkg.sv
// ---------------------------------------------------------------------------
// deq_pkg
// Shared types and constants for the double-ended queue core.
// ---------------------------------------------------------------------------
package deq_pkg;

    localparam int OP_W       = 3;
    localparam int IO_DATA_W  = 32;
    localparam int POS_W      = 4;
    localparam int STATUS_W   = 2;
    localparam int CNT_OUT_W  = 5;

    localparam int DEF_DEPTH      = 16;
    localparam int DEF_DATA_WIDTH = 32;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_READ_FRONT = 3'd2,
        OP_READ_BACK  = 3'd3,
        OP_READ_POS   = 3'd4,
        OP_ERASE_POS  = 3'd5
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_FULL  = 2'd1,
        STAT_EMPTY = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

endpackage

>>> sv/double_ended_queue_core.sv
// An accepted word moves the sequencer to S_FIN, through S_ERASE for an erase that must shift
// elements; from S_FIN the result registers load once the output is free. Erase at position p
// moves count - 1 - p elements, one element per cycle (read one slot, write the previous).
// One word is processed at a time; a new word is accepted while the last result waits.
// Reset (synchronous, active low) clears head, count and handshake state; the element
// memory is not cleared, and no entry is read before it has been written.
// ---------------------------------------------------------------------------
// double_ended_queue_core
// Bounded double-ended queue on a ring memory with a small sequencer.
// ---------------------------------------------------------------------------
module double_ended_queue_core #(
    parameter int DEPTH      = deq_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic [deq_pkg::OP_W-1:0]       i_opcode,
    input  logic [deq_pkg::IO_DATA_W-1:0]  i_data_in,
    input  logic [deq_pkg::POS_W-1:0]      i_position,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [deq_pkg::IO_DATA_W-1:0]  o_data_out,
    output logic [deq_pkg::STATUS_W-1:0]   o_status,
    output logic [deq_pkg::CNT_OUT_W-1:0]  o_count_out
);

    import deq_pkg::*;

    localparam int AW  = $clog2(DEPTH);
    localparam int AW1 = AW + 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam logic [AW1-1:0] DEPTH_S = AW1'(DEPTH);
    localparam logic [CW-1:0]  DEPTH_C = CW'(DEPTH);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_ERASE = 3'b010,
        S_FIN   = 3'b100
    } t_state;

    function automatic logic [AW-1:0] f_slot(input logic [AW-1:0] base,
                                             input logic [AW-1:0] off);
        logic [AW1-1:0] s;
        s = {1'b0, base} + {1'b0, off};
        if (s >= DEPTH_S) begin
            s = s - DEPTH_S;
        end
        return s[AW-1:0];
    endfunction

    t_state                r_state, n_state;
    logic [AW-1:0]         r_head, n_head;
    logic [CW-1:0]         r_count, n_count;
    logic [CW-1:0]         r_left, n_left;
    logic [AW-1:0]         r_wslot, n_wslot;
    logic [AW-1:0]         r_rslot, n_rslot;
    logic                  r_rd_sel, n_rd_sel;
    t_status               r_status, n_status;
    logic                  r_ovalid, n_ovalid;
    logic [IO_DATA_W-1:0]  r_odata;
    t_status               r_ostatus;
    logic [CNT_OUT_W-1:0]  r_ocount;

    logic                  w_accept;
    logic                  w_out_free;
    logic                  w_load;
    logic                  w_full;
    logic                  w_empty;
    logic [PW-1:0]         w_pos_ext;
    logic                  w_range;
    logic [AW-1:0]         w_pos_slot;
    logic [CW-1:0]         w_erase_left;
    logic [DATA_WIDTH+IO_DATA_W-1:0] w_in_ext;
    logic [DATA_WIDTH+IO_DATA_W-1:0] w_rd_ext;
    logic [CW+CNT_OUT_W-1:0]         w_cnt_ext;

    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [DATA_WIDTH-1:0] w_wr_data;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [DATA_WIDTH-1:0] w_rd_data;

    deq_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .AW         (AW)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    assign o_in_stall   = !i_rst_n || (r_state != S_IDLE);
    assign w_accept     = i_in_valid && !o_in_stall;
    assign w_out_free   = !r_ovalid || !i_out_stall;
    assign w_load       = (r_state == S_FIN) && w_out_free;

    assign w_full       = (r_count == DEPTH_C);
    assign w_empty      = (r_count == '0);
    assign w_pos_ext    = PW'(i_position);
    assign w_range      = (w_pos_ext >= PW'(r_count));
    assign w_pos_slot   = f_slot(r_head, w_pos_ext[AW-1:0]);
    assign w_erase_left = r_count - w_pos_ext[CW-1:0] - CW'(1);

    assign w_in_ext  = {{DATA_WIDTH{1'b0}}, i_data_in};
    assign w_rd_ext  = {{IO_DATA_W{1'b0}}, w_rd_data};
    assign w_cnt_ext = {{CNT_OUT_W{1'b0}}, r_count};

    always_comb begin
        n_state   = r_state;
        n_head    = r_head;
        n_count   = r_count;
        n_left    = r_left;
        n_wslot   = r_wslot;
        n_rslot   = r_rslot;
        n_rd_sel  = r_rd_sel;
        n_status  = r_status;
        w_wr_en   = 1'b0;
        w_wr_addr = r_wslot;
        w_wr_data = w_rd_data;
        w_rd_en   = 1'b0;
        w_rd_addr = r_rslot;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_FIN;
                    n_rd_sel = 1'b0;
                    n_status = STAT_OK;
                    unique case (i_opcode) inside
                        OP_PUSH_FRONT: begin
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                n_head    = f_slot(r_head, AW'(DEPTH - 1));
                                w_wr_en   = 1'b1;
                                w_wr_addr = f_slot(r_head, AW'(DEPTH - 1));
                                w_wr_data = w_in_ext[DATA_WIDTH-1:0];
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_PUSH_BACK: begin
                            if (w_full) begin
                                n_status = STAT_FULL;
                            end else begin
                                w_wr_en   = 1'b1;
                                w_wr_addr = f_slot(r_head, r_count[AW-1:0]);
                                w_wr_data = w_in_ext[DATA_WIDTH-1:0];
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_READ_FRONT, OP_READ_BACK: begin
                            if (w_empty) begin
                                n_status = STAT_EMPTY;
                            end else begin
                                w_rd_en  = 1'b1;
                                n_rd_sel = 1'b1;
                                if (i_opcode == OP_READ_FRONT) begin
                                    w_rd_addr = r_head;
                                end else begin
                                    w_rd_addr = f_slot(r_head, AW'(r_count - CW'(1)));
                                end
                            end
                        end
                        OP_READ_POS: begin
                            if (w_range) begin
                                n_status = STAT_RANGE;
                            end else begin
                                w_rd_en   = 1'b1;
                                w_rd_addr = w_pos_slot;
                                n_rd_sel  = 1'b1;
                            end
                        end
                        OP_ERASE_POS: begin
                            if (w_range) begin
                                n_status = STAT_RANGE;
                            end else begin
                                n_count = r_count - CW'(1);
                                if (w_erase_left != '0) begin
                                    w_rd_en   = 1'b1;
                                    w_rd_addr = f_slot(w_pos_slot, AW'(1));
                                    n_wslot   = w_pos_slot;
                                    n_rslot   = f_slot(f_slot(w_pos_slot, AW'(1)), AW'(1));
                                    n_left    = w_erase_left - CW'(1);
                                    n_state   = S_ERASE;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_ERASE: begin
                // shift one element toward the front per cycle
                w_wr_en   = 1'b1;
                w_wr_addr = r_wslot;
                w_wr_data = w_rd_data;
                n_wslot   = f_slot(r_wslot, AW'(1));
                if (r_left != '0) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_rslot;
                    n_rslot   = f_slot(r_rslot, AW'(1));
                    n_left    = r_left - CW'(1);
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (w_load) begin
            n_ovalid = 1'b1;
        end else if (!i_out_stall) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_count  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_count  <= n_count;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_left   <= n_left;
        r_wslot  <= n_wslot;
        r_rslot  <= n_rslot;
        r_rd_sel <= n_rd_sel;
        r_status <= n_status;
        if (w_load) begin
            r_odata   <= r_rd_sel ? w_rd_ext[IO_DATA_W-1:0] : '0;
            r_ostatus <= r_status;
            r_ocount  <= w_cnt_ext[CNT_OUT_W-1:0];
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_data_out  = r_odata;
    assign o_status    = r_ostatus;
    assign o_count_out = r_ocount;

endmodule

>>> sv/deq_ram.sv
// ---------------------------------------------------------------------------
// deq_ram
// Element store: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module deq_ram #(
    parameter int DEPTH      = deq_pkg::DEF_DEPTH,
    parameter int DATA_WIDTH = deq_pkg::DEF_DATA_WIDTH,
    parameter int AW         = $clog2(DEPTH)
) (
    input  logic                  i_clk,
    input  logic                  i_wr_en,
    input  logic [AW-1:0]         i_wr_addr,
    input  logic [DATA_WIDTH-1:0] i_wr_data,
    input  logic                  i_rd_en,
    input  logic [AW-1:0]         i_rd_addr,
    output logic [DATA_WIDTH-1:0] o_rd_data
);

    logic [DATA_WIDTH-1:0] r_mem [DEPTH];
    logic [DATA_WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> sv/deq_checker.sv
// ---------------------------------------------------------------------------
// deq_checker
// Port-level checks for the double-ended queue core, bound to the top level.
// ---------------------------------------------------------------------------
module deq_checker #(
    parameter int DEPTH = deq_pkg::DEF_DEPTH
) (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input logic [deq_pkg::IO_DATA_W-1:0]  o_data_out,
    input logic [deq_pkg::STATUS_W-1:0]   o_status,
    input logic [deq_pkg::CNT_OUT_W-1:0]  o_count_out
);

    import deq_pkg::*;

    localparam logic [CNT_OUT_W-1:0] FULL_CNT = CNT_OUT_W'(DEPTH);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_data_out)
            && $stable(o_status) && $stable(o_count_out))
        else $error("result word changed while stalled");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_FULL) |-> (o_count_out == FULL_CNT)
            && (o_data_out == '0))
        else $error("full status with count not at depth");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_EMPTY) |-> (o_count_out == '0)
            && (o_data_out == '0))
        else $error("empty status with nonzero count or data");

    a_range_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status == STAT_RANGE) |-> (o_data_out == '0))
        else $error("out of range status with nonzero data");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result word valid right after reset");

endmodule

bind double_ended_queue_core deq_checker #(.DEPTH(DEPTH)) u_deq_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_data_out  (o_data_out),
    .o_status    (o_status),
    .o_count_out (o_count_out)
);

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Tests the double-ended queue core against a behavioral ring-store model.
// Directed words cover the empty and full edges, both pushes, every read,
// and erase at both ends. Long random runs with fill and drain phases follow.
// Random idle and stall gaps are applied on both sides. Every result is
// checked field by field, in order.
// ---------------------------------------------------------------------------
module testbench;

    import deq_pkg::*;

    localparam logic [OP_W-1:0] OP_IDLE_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_IDLE_7 = 3'd7;
    localparam int              RING_SIZE = 16;

    typedef struct {
        logic [IO_DATA_W-1:0] data;
        t_status              status;
        logic [CNT_OUT_W-1:0] count;
    } t_deq_result;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [OP_W-1:0]       i_opcode;
    logic [IO_DATA_W-1:0]  i_data_in;
    logic [POS_W-1:0]      i_position;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [IO_DATA_W-1:0]  o_data_out;
    logic [STATUS_W-1:0]   o_status;
    logic [CNT_OUT_W-1:0]  o_count_out;

    logic [IO_DATA_W-1:0]  ring_store [RING_SIZE];
    logic [POS_W-1:0]      ring_head;
    int                    ring_count;
    t_deq_result           expected_results [$];
    int                    error_count;
    bit                    no_idle;

    double_ended_queue_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_opcode    (i_opcode),
        .i_data_in   (i_data_in),
        .i_position  (i_position),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_out  (o_data_out),
        .o_status    (o_status),
        .o_count_out (o_count_out)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    function automatic int draw_gap();
        return no_idle ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic t_deq_result deque_apply(input logic [OP_W-1:0] op,
                                                input logic [IO_DATA_W-1:0] data,
                                                input logic [POS_W-1:0] pos);
        t_deq_result res;
        int          k;
        res.data   = '0;
        res.status = STAT_OK;
        case (op)
            OP_PUSH_FRONT: begin
                if (ring_count >= RING_SIZE) begin
                    res.status = STAT_FULL;
                end else begin
                    ring_head = ring_head - 1'b1;
                    ring_store[ring_head] = data;
                    ring_count++;
                end
            end
            OP_PUSH_BACK: begin
                if (ring_count >= RING_SIZE) begin
                    res.status = STAT_FULL;
                end else begin
                    ring_store[ring_head + POS_W'(ring_count)] = data;
                    ring_count++;
                end
            end
            OP_READ_FRONT: begin
                if (ring_count == 0) res.status = STAT_EMPTY;
                else res.data = ring_store[ring_head];
            end
            OP_READ_BACK: begin
                if (ring_count == 0) res.status = STAT_EMPTY;
                else res.data = ring_store[ring_head + POS_W'(ring_count - 1)];
            end
            OP_READ_POS: begin
                if (int'(pos) >= ring_count) res.status = STAT_RANGE;
                else res.data = ring_store[ring_head + pos];
            end
            OP_ERASE_POS: begin
                if (int'(pos) >= ring_count) begin
                    res.status = STAT_RANGE;
                end else begin
                    for (k = int'(pos); k + 1 < ring_count; k++)
                        ring_store[ring_head + POS_W'(k)] = ring_store[ring_head + POS_W'(k + 1)];
                    ring_count--;
                end
            end
            default: ;
        endcase
        res.count = CNT_OUT_W'(ring_count);
        return res;
    endfunction

    task automatic send_word(input logic [OP_W-1:0] op, input logic [IO_DATA_W-1:0] data,
                             input logic [POS_W-1:0] pos);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_opcode   <= op;
        i_data_in  <= data;
        i_position <= pos;
        do @(posedge i_clk); while (o_in_stall);
        expected_results.insert(expected_results.size(), deque_apply(op, data, pos));
    endtask

    task automatic test_empty_queue();
        send_word(OP_READ_FRONT, 32'hFFFF_FFFF, 4'd0);
        send_word(OP_READ_BACK, 32'h0, 4'd0);
        send_word(OP_READ_POS, 32'h0, 4'd15);
        send_word(OP_ERASE_POS, 32'h0, 4'd0);
        send_word(OP_IDLE_7, 32'hFFFF_FFFF, 4'd15);
    endtask

    task automatic test_fill_to_full();
        int i;
        for (i = 0; i < RING_SIZE; i++) begin
            case (i % 4)
                0: send_word(OP_PUSH_BACK, 32'h0000_0000, 4'd0);
                1: send_word(OP_PUSH_FRONT, 32'hFFFF_FFFF, 4'd15);
                2: send_word(OP_PUSH_BACK, 32'hA5A5_5A5A ^ i, 4'd0);
                default: send_word(OP_PUSH_FRONT, $urandom, 4'd0);
            endcase
        end
        send_word(OP_PUSH_FRONT, 32'h1234_5678, 4'd0);
        send_word(OP_PUSH_BACK, 32'h8765_4321, 4'd0);
        send_word(OP_READ_POS, 32'h0, 4'd15);
        send_word(OP_READ_BACK, 32'h0, 4'd0);
    endtask

    task automatic test_erase_ends();
        send_word(OP_ERASE_POS, 32'h0, 4'd15);
        send_word(OP_ERASE_POS, 32'h0, 4'd0);
        send_word(OP_READ_FRONT, 32'h0, 4'd0);
    endtask

    task automatic test_random_ops(input int n_words);
        int               i;
        int               mode;
        int               r;
        int               push_pct;
        int               erase_pct;
        logic [OP_W-1:0]  op;
        logic [POS_W-1:0] pos;
        for (i = 0; i < n_words; i++) begin
            if (i % 50 == 0) begin
                mode    = $urandom_range(0, 2);
                no_idle = ($urandom_range(0, 3) == 0);
            end
            push_pct  = (mode == 0) ? 70 : (mode == 1) ? 20 : 45;
            erase_pct = (mode == 1) ? 35 : 12;
            r = $urandom_range(0, 99);
            if (r < push_pct) begin
                op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
            end else if (r < push_pct + erase_pct) begin
                op = OP_ERASE_POS;
            end else if (r < 97) begin
                case ($urandom_range(0, 2))
                    0: op = OP_READ_FRONT;
                    1: op = OP_READ_BACK;
                    default: op = OP_READ_POS;
                endcase
            end else begin
                op = $urandom_range(0, 1) ? OP_IDLE_6 : OP_IDLE_7;
            end
            if (ring_count > 0 && $urandom_range(0, 3) != 0)
                pos = POS_W'($urandom_range(0, ring_count - 1));
            else
                pos = POS_W'($urandom_range(0, 15));
            send_word(op, $urandom, pos);
        end
        no_idle = 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_results.size() == 0) begin
                $error("result with no word pending: data_out %h status %0d count %0d",
                       o_data_out, o_status, o_count_out);
                error_count++;
            end else begin
                t_deq_result exp_res;
                exp_res = expected_results[0];
                expected_results.delete(0);
                if (o_data_out !== exp_res.data) begin
                    $error("data_out mismatch: expected %h, got %h", exp_res.data, o_data_out);
                    error_count++;
                end
                if (o_status !== exp_res.status) begin
                    $error("status mismatch: expected %0d, got %0d", exp_res.status, o_status);
                    error_count++;
                end
                if (o_count_out !== exp_res.count) begin
                    $error("count_out mismatch: expected %0d, got %0d",
                           exp_res.count, o_count_out);
                    error_count++;
                end
            end
        end
    end

    initial begin
        int n;
        wait (i_rst_n);
        forever begin
            n = draw_gap();
            if (n > 0) begin
                i_out_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    initial begin
        #1_000_000;
        $display("FAIL");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_out_stall = 1'b0;
        i_opcode    = OP_READ_FRONT;
        i_data_in   = '0;
        i_position  = '0;
        ring_head   = '0;
        ring_count  = 0;
        error_count = 0;
        no_idle     = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_queue();
        test_fill_to_full();
        test_erase_ends();
        test_random_ops(1580);

        i_in_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

>>> filelist.f
sv/deq_pkg.sv
sv/deq_ram.sv
sv/double_ended_queue_core.sv
sv/deq_checker.sv
bench/testbench.sv
